// ----- hw/rtl/ppu_pkg.sv -----
// Package for the packed pixel unpacker: widths, pixel size codes and bit reordering.
package ppu_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned LG_W    = 3;
  localparam int unsigned IDX_W   = $clog2(WORD_W);

  // Pixel size codes (log2 of bits per pixel)
  typedef enum logic [LG_W-1:0] {
    PIX_1B  = 3'd0,
    PIX_2B  = 3'd1,
    PIX_4B  = 3'd2,
    PIX_8B  = 3'd3,
    PIX_16B = 3'd4,
    PIX_32B = 3'd5
  } pix_size_t;

  localparam logic [LG_W-1:0] LG_RESET = PIX_8B;

  // Codes beyond the largest size behave as 32-bit pixels
  function automatic pix_size_t size_decode(logic [LG_W-1:0] lg);
    pix_size_t s;
    s = PIX_32B;
    unique case (lg)
      PIX_1B:  s = PIX_1B;
      PIX_2B:  s = PIX_2B;
      PIX_4B:  s = PIX_4B;
      PIX_8B:  s = PIX_8B;
      PIX_16B: s = PIX_16B;
      default: s = PIX_32B;
    endcase
    return s;
  endfunction

  // Index of the last pixel in a word
  function automatic logic [IDX_W-1:0] last_index(pix_size_t s);
    logic [IDX_W-1:0] n;
    n = '1;
    unique case (s)
      PIX_1B:  n = IDX_W'(63);
      PIX_2B:  n = IDX_W'(31);
      PIX_4B:  n = IDX_W'(15);
      PIX_8B:  n = IDX_W'(7);
      PIX_16B: n = IDX_W'(3);
      default: n = IDX_W'(1);
    endcase
    return n;
  endfunction

  // Reverse sub-byte fields within each byte so the most significant field leads
  function automatic logic [WORD_W-1:0] reorder(pix_size_t s, logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x;
    unique case (s)
      PIX_1B: begin
        y = ((x & 64'h0101010101010101) << 7) | ((x & 64'h0202020202020202) << 5)
          | ((x & 64'h0404040404040404) << 3) | ((x & 64'h0808080808080808) << 1)
          | ((x & 64'h1010101010101010) >> 1) | ((x & 64'h2020202020202020) >> 3)
          | ((x & 64'h4040404040404040) >> 5) | ((x & 64'h8080808080808080) >> 7);
      end
      PIX_2B: begin
        y = ((x & 64'h0303030303030303) << 6) | ((x & 64'h0c0c0c0c0c0c0c0c) << 2)
          | ((x & 64'h3030303030303030) >> 2) | ((x & 64'hc0c0c0c0c0c0c0c0) >> 6);
      end
      PIX_4B: begin
        y = ((x & 64'h0f0f0f0f0f0f0f0f) << 4) | ((x & 64'hf0f0f0f0f0f0f0f0) >> 4);
      end
      default: y = x;
    endcase
    return y;
  endfunction

endpackage

// ----- hw/rtl/packed_pixel_unpacker.sv -----
// Top level of the packed pixel unpacker: word register, pixel shifter and result register.
//
// Usage
//   Input: present in_raw_word and in_last_word with start high; the word is
//   taken at a rising edge where start is high and busy is low.
//   Output: each pixel appears on out_pixel for one cycle with out_valid high,
//   out_word_end on the last pixel of a word and out_frame_end on the last
//   pixel of a word that came with in_last_word set. The receiver cannot stall.
//   Configuration: cfg_wr_en writes cfg_wr_data into the pixel size register
//   (log2 of bits per pixel, codes six and seven act as 32-bit pixels).
//   Write it only while the block is idle.
// Timing
//   The first pixel of a word passes from the word register into the result
//   register, from which it drives the result ports.
//   A word yields 64/B pixels at one per cycle (2 at 32 bits, 8 at 8 bits,
//   64 at 1 bit); the word register shifts by B each cycle and sets that
//   rate. The next word is accepted in the cycle the last pixel of the
//   current one moves to the result register, so words follow with no gap.
// Reset
//   rst_n low (synchronous) drops any word in flight, clears the strobe and
//   sets 8-bit pixels.
module packed_pixel_unpacker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ppu_pkg::WORD_W-1:0]    in_raw_word,
  input  logic                          in_last_word,
  output logic                          out_valid,
  output logic [ppu_pkg::PIXEL_W-1:0]   out_pixel,
  output logic                          out_word_end,
  output logic                          out_frame_end,
  input  logic                          cfg_wr_en,
  input  logic [ppu_pkg::LG_W-1:0]      cfg_wr_data
);

  logic [ppu_pkg::LG_W-1:0]    lg_r;
  ppu_pkg::pix_size_t          size;

  logic                        word_vld_r;
  logic [ppu_pkg::WORD_W-1:0]  word_r, word_nxt;
  logic [ppu_pkg::IDX_W-1:0]   idx_r;
  logic                        last_r;
  logic                        end_now;
  logic                        accept;

  logic                        out_valid_r;
  logic [ppu_pkg::PIXEL_W-1:0] pixel_r, pixel_nxt;
  logic                        word_end_r;
  logic                        frame_end_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= ppu_pkg::LG_RESET;
    end else if (cfg_wr_en) begin
      lg_r <= cfg_wr_data;
    end
  end

  assign size    = ppu_pkg::size_decode(lg_r);
  assign end_now = word_vld_r && (idx_r == ppu_pkg::last_index(size));
  // Free when empty, or when the current word hands over its last pixel
  assign busy    = word_vld_r && !end_now;
  assign accept  = start && !busy;

  // Advance the word by one pixel width
  always_comb begin
    word_nxt = word_r;
    unique case (size)
      ppu_pkg::PIX_1B:  word_nxt = word_r >> 1;
      ppu_pkg::PIX_2B:  word_nxt = word_r >> 2;
      ppu_pkg::PIX_4B:  word_nxt = word_r >> 4;
      ppu_pkg::PIX_8B:  word_nxt = word_r >> 8;
      ppu_pkg::PIX_16B: word_nxt = word_r >> 16;
      default:          word_nxt = word_r >> 32;
    endcase
  end

  // Take the low B bits, zero-extended
  always_comb begin
    pixel_nxt = '0;
    unique case (size)
      ppu_pkg::PIX_1B:  pixel_nxt = ppu_pkg::PIXEL_W'(word_r[0:0]);
      ppu_pkg::PIX_2B:  pixel_nxt = ppu_pkg::PIXEL_W'(word_r[1:0]);
      ppu_pkg::PIX_4B:  pixel_nxt = ppu_pkg::PIXEL_W'(word_r[3:0]);
      ppu_pkg::PIX_8B:  pixel_nxt = ppu_pkg::PIXEL_W'(word_r[7:0]);
      ppu_pkg::PIX_16B: pixel_nxt = ppu_pkg::PIXEL_W'(word_r[15:0]);
      default:          pixel_nxt = word_r[31:0];
    endcase
  end

  // Word register control: load on accept, otherwise advance or drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_vld_r <= 1'b0;
      idx_r      <= '0;
    end else if (accept) begin
      word_vld_r <= 1'b1;
      idx_r      <= '0;
    end else if (end_now) begin
      word_vld_r <= 1'b0;
    end else if (word_vld_r) begin
      idx_r <= idx_r + ppu_pkg::IDX_W'(1);
    end
  end

  // Word payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= ppu_pkg::reorder(size, in_raw_word);
      last_r <= in_last_word;
    end else if (word_vld_r) begin
      word_r <= word_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= word_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (word_vld_r) begin
      pixel_r     <= pixel_nxt;
      word_end_r  <= end_now;
      frame_end_r <= end_now && last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = pixel_r;
  assign out_word_end  = word_end_r;
  assign out_frame_end = frame_end_r;

endmodule

// ----- hw/rtl/ppu_checker.sv -----
// Port-level checker for the packed pixel unpacker, with its bind.
module ppu_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_word_end,
  input logic out_frame_end
);

  // Frame end only ever marks the last pixel of a word
  a_frame_on_word_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_word_end)
    else $error("frame end without word end");

  // Every word has at least two pixels, so the block is busy after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("not busy after accepting a word");

  // First pixel of an accepted word shows once it has passed the word and result registers
  a_first_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("no pixel two cycles after accept");

  // No strobe straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("strobe right after reset");

endmodule

bind packed_pixel_unpacker ppu_checker u_ppu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_word_end  (out_word_end),
  .out_frame_end (out_frame_end)
);

// ----- bench/tb.sv -----
// Testbench for the packed pixel unpacker: directed and random words at every pixel size.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_W  = ppu_pkg::WORD_W;
  localparam int unsigned PIXEL_W = ppu_pkg::PIXEL_W;
  localparam int unsigned LG_W    = ppu_pkg::LG_W;

  // Codes beyond the largest pixel size; the block treats them as 32-bit pixels
  localparam logic [LG_W-1:0] LG_SPARE_LO = 3'd6;
  localparam logic [LG_W-1:0] LG_SPARE_HI = 3'd7;

  // Cycles with no transaction on either side before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  // Random words per configuration phase
  localparam int unsigned PHASE_WORDS = 19;

  // One expected pixel as it should leave the block
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               word_end;
    logic               frame_end;
  } pixel_rec_t;

  // Keeps the expected pixels of every accepted word and checks the block's
  // output stream against them in order.
  class pixel_book;
    pixel_rec_t pending_pixels[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    // Swap the order of the b-bit fields inside each byte (b below 8 only)
    static function logic [WORD_W-1:0] flip_fields(int unsigned b, logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] y;
      int unsigned per;
      y = x;
      if (b < 8) begin
        per = 8 / b;
        for (int unsigned by = 0; by < 8; by++)
          for (int unsigned j = 0; j < per; j++)
            for (int unsigned t = 0; t < b; t++)
              y[by*8 + (per-1-j)*b + t] = x[by*8 + j*b + t];
      end
      return y;
    endfunction

    // Split an accepted word into its pixels under the given size code
    function void note_word(logic [WORD_W-1:0] raw, logic last, logic [LG_W-1:0] code);
      logic [LG_W-1:0] lg;
      int unsigned b, count;
      logic [WORD_W-1:0] word, mask;
      pixel_rec_t rec;
      lg = (code > ppu_pkg::PIX_32B) ? LG_W'(ppu_pkg::PIX_32B) : code;
      b = 1 << lg;
      count = WORD_W >> lg;
      mask = (b >= 32) ? 64'h0000_0000_FFFF_FFFF : ((64'd1 << b) - 64'd1);
      word = flip_fields(b, raw);
      for (int unsigned k = 0; k < count; k++) begin
        rec.pixel     = PIXEL_W'((word >> (k * b)) & mask);
        rec.word_end  = (k + 1 == count);
        rec.frame_end = (k + 1 == count) && last;
        pending_pixels.push_back(rec);
      end
    endfunction

    // Compare one output pixel with the oldest expectation
    function void check_pixel(logic [PIXEL_W-1:0] pixel, logic word_end, logic frame_end);
      pixel_rec_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel 0x%08h with nothing outstanding", pixel);
        fail_count++;
        return;
      end
      want = pending_pixels.pop_front();
      if (pixel !== want.pixel) begin
        $error("pixel: expected 0x%08h, got 0x%08h", want.pixel, pixel);
        fail_count++;
      end
      if (word_end !== want.word_end) begin
        $error("word_end: expected %0b, got %0b", want.word_end, word_end);
        fail_count++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
        fail_count++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_pixels.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [WORD_W-1:0]   in_raw_word;
  logic                in_last_word;
  logic                out_valid;
  logic [PIXEL_W-1:0]  out_pixel;
  logic                out_word_end;
  logic                out_frame_end;
  logic                cfg_wr_en;
  logic [LG_W-1:0]     cfg_wr_data;

  // Size code the block holds, tracked alongside it
  logic [LG_W-1:0]     size_code;
  int unsigned         quiet_cycles = 0;
  pixel_book           book;

  packed_pixel_unpacker dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_raw_word  (in_raw_word),
    .in_last_word (in_last_word),
    .out_valid    (out_valid),
    .out_pixel    (out_pixel),
    .out_word_end (out_word_end),
    .out_frame_end(out_frame_end),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: the receiver cannot stall, so take every strobed pixel at
  // the edge that closes its cycle and check it straight away.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      book.check_pixel(out_pixel, out_word_end, out_frame_end);
  end

  // Watchdog: count cycles in which neither side moves a transaction and
  // abandon the run once the count reaches the limit.
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("packed_pixel_unpacker verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one word and hold it until the block takes it; the edge that
  // accepts it is the one where start is high and busy is low. Start stays
  // high on return so a burst can follow without a gap.
  task automatic send_word(input logic [WORD_W-1:0] raw, input logic last);
    in_raw_word  <= raw;
    in_last_word <= last;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    book.note_word(raw, last, size_code);
  endtask

  // Wait until every expected pixel has come out and the block is idle.
  // Sample at the falling edge so the check never races the output monitor,
  // then realign to a rising edge for driving.
  task automatic wait_for_drain();
    do @(negedge clk); while (book.outstanding() != 0 || busy);
    @(posedge clk);
  endtask

  // Write the pixel size register while the block is idle
  task automatic write_pixel_size(input logic [LG_W-1:0] code);
    start <= 1'b0;
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    size_code   =  code;
  endtask

  // Random 64-bit payload, now and then a solid pattern
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Random words in bursts with random gaps. Most of them form frames of a
  // few words with only the closing word flagged; the rest carry a random
  // last-word flag. Halfway through, hold off until the block has drained.
  // Start is left high after the final word; the caller drops it.
  task automatic drive_random_words(input int unsigned total);
    int unsigned sent, burst, gap, frame_left, pause_at;
    logic [WORD_W-1:0] raw;
    logic last;
    sent       = 0;
    frame_left = 0;
    pause_at   = total / 2;
    while (sent < total) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && sent < total) begin
        raw = random_word();
        if ($urandom_range(0, 7) == 0) begin
          last = 1'($urandom_range(0, 1));
        end else begin
          if (frame_left == 0)
            frame_left = $urandom_range(1, 6);
          last = (frame_left == 1);
          frame_left--;
        end
        send_word(raw, last);
        sent++;
        burst--;
        if (sent == pause_at) begin
          start <= 1'b0;
          wait_for_drain();
        end
      end
      // A quarter of the bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (sent < total && gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [WORD_W-1:0] patterns [8];
    logic [LG_W-1:0]   phase_codes [8];
    book = new();
    size_code    = ppu_pkg::LG_RESET;

    // Drive every input to a known value and hold reset
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_raw_word  <= '0;
    in_last_word <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    patterns[0] = 64'h0000_0000_0000_0000;
    patterns[1] = 64'h8000_0000_0000_0001;
    patterns[2] = 64'h0123_4567_89AB_CDEF;
    patterns[3] = 64'hA5A5_5A5A_C3C3_3C3C;
    patterns[4] = 64'h7FFF_FFFF_8000_0000;
    patterns[5] = 64'hFFFF_0000_FFFF_0001;
    patterns[6] = 64'h1248_8421_0F0F_F0F0;
    patterns[7] = 64'hDEAD_BEEF_0BAD_F00D;

    // Directed part: the reset size first, then every code including the
    // two spare ones that fall back to 32-bit pixels
    send_word(64'h0706_0504_0302_0100, 1'b0);
    send_word('1, 1'b1);
    send_word(patterns[3], 1'b1);
    for (int unsigned c = 0; c < 8; c++) begin
      write_pixel_size(LG_W'(c));
      send_word('1, 1'b1);
      send_word(patterns[c], 1'b0);
    end

    // Random part: a phase per setting, extremes and spare codes among them
    phase_codes[0] = ppu_pkg::PIX_1B;
    phase_codes[1] = ppu_pkg::PIX_32B;
    phase_codes[2] = LG_SPARE_HI;
    phase_codes[3] = ppu_pkg::PIX_8B;
    phase_codes[4] = ppu_pkg::PIX_2B;
    phase_codes[5] = LG_SPARE_LO;
    phase_codes[6] = ppu_pkg::PIX_4B;
    phase_codes[7] = ppu_pkg::PIX_16B;
    for (int unsigned p = 0; p < 8; p++) begin
      write_pixel_size(phase_codes[p]);
      drive_random_words(PHASE_WORDS);
    end

    // Let the last pixels out, then allow a few cycles for anything stray
    start <= 1'b0;
    wait_for_drain();
    repeat (8) @(posedge clk);

    if (book.fail_count == 0 && book.outstanding() == 0) begin
      $display("packed_pixel_unpacker verification clean");
    end else begin
      $display("packed_pixel_unpacker verification failed");
    end
    $finish;
  end

endmodule
